// ----- rtl/esnt_pkg.sv -----
// Shared types and constants for the expiry sorted neighbor table.
// No dependencies.
package esnt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HandleW = 8;
  localparam int unsigned ActW = 4;
  localparam logic [TimeW-1:0] HoldReset = 32'd6000;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 4'd0,
    ACT_FIND = 4'd1,
    ACT_FIND_NEXT = 4'd2,
    ACT_PEEK_FIRST = 4'd3,
    ACT_PEEK_NEXT = 4'd4,
    ACT_REMOVE = 4'd5,
    ACT_CHECK = 4'd6,
    ACT_CLEAR = 4'd7,
    ACT_SAVE = 4'd8,
    ACT_RESTORE = 4'd9
  } action_t;

  localparam logic CFG_HOLD = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // one table entry
  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [KeyW-1:0] key;
    logic [TimeW-1:0] expiry;
    logic [HandleW-1:0] handle;
  } entry_t;

  // compare unit request
  typedef struct packed {
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

// ----- rtl/esnt_cmp.sv -----
// Shared compare unit: one 32-bit unsigned compare per cycle.
// Depends on esnt_pkg.
module esnt_cmp
  import esnt_pkg::*;
(
  input  cmp_req_t req,
  output cmp_res_t res
);
  assign res.eq = (req.a == req.b);
  assign res.lt = (req.a < req.b);
  assign res.gt = (req.a > req.b);
endmodule

// ----- rtl/expiry_sorted_neighbor_table.sv -----
// Expiry sorted neighbor table, top level.
// Depends on esnt_pkg and esnt_cmp.
//
// Usage: requests arrive on the valid/ready input channel (action, address,
// order_key, entry_handle, now). Each request produces exactly one result
// on the valid/ready output channel (found, handle_out, address_out,
// expired, status). The table lives in one memory with one read and one
// write port; a sequencer walks it entry by entry using a single
// shared compare unit.
// Insert walks back from the end of the table, find and find next walk
// forward from their start slot, remove shifts the entries behind the
// removed one down, and check with a cursor reads that one entry; each
// step reads one entry through the memory's registered read port. The
// result then moves into the output register.
// One request is in flight at a time: ready is low from acceptance until
// the result is registered. The result sits in an output register; the
// block accepts the next request while that result still waits.
// Reset (synchronous, active high) empties the table, clears both cursors,
// and loads hold_time = 6000, order_mode = 0. Memory contents are not
// cleared; only entries below the count are ever used.
// A stalled receiver holds the result; a new request can be taken but its
// result waits until the output register is free.
module expiry_sorted_neighbor_table
  import esnt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ActW-1:0]    action,
  input  logic [AddrW-1:0]   address,
  input  logic [KeyW-1:0]    order_key,
  input  logic [HandleW-1:0] entry_handle,
  input  logic [TimeW-1:0]   now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [HandleW-1:0] handle_out,
  output logic [AddrW-1:0]   address_out,
  output logic               expired,
  output logic               status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TimeW-1:0]   cfg_data
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_SRCH_RD, S_SRCH_CMP,
    S_REM_RD, S_REM_WR, S_CHK_RD, S_CHK_CMP, S_OUT_RD, S_OUT_WAIT, S_DONE
  } state_t;

  state_t state;

  // memory
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // config
  logic [TimeW-1:0] hold_time;
  logic order_mode;

  // request registers
  logic [AddrW-1:0] r_addr;
  entry_t new_ent;
  logic [TimeW-1:0] r_now;

  // table state
  logic [CntW-1:0] count;
  logic cur_ok;
  logic [CntW-1:0] cursor;
  logic sav_ok;
  logic [CntW-1:0] saved;
  logic [CntW-1:0] pos;  // scan / shift position
  logic res_expired;
  logic res_status;
  logic pend;  // result ready to load into output register
  logic load_out;

  // shared compare unit
  cmp_req_t cmp_req;
  cmp_res_t cmp_res;
  esnt_cmp u_cmp (.req(cmp_req), .res(cmp_res));

  always_comb begin
    cmp_req.a = r_addr;
    cmp_req.b = rd_data.address;
    unique case (state)
      S_INS_CMP: begin
        if (order_mode) begin
          cmp_req.a = new_ent.address;
          cmp_req.b = rd_data.address;
        end else begin
          cmp_req.a = new_ent.key;
          cmp_req.b = rd_data.key;
        end
      end
      S_CHK_CMP: begin
        cmp_req.a = rd_data.expiry;
        cmp_req.b = r_now;
      end
      default: ;
    endcase
  end

  // expiry = now + hold, saturated
  logic [TimeW:0] exp_sum;
  assign exp_sum = {1'b0, now} + {1'b0, hold_time};

  logic goes_first;
  assign goes_first = order_mode ? cmp_res.gt : cmp_res.lt;

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = pos[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = pos[IdxW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_INS_RD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(pos - 1'b1);
      end
      S_INS_CMP: begin
        // shift predecessor up one slot when new entry goes before it
        if (goes_first) begin
          wr_en = 1'b1;
        end
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_data = new_ent;
      end
      S_SRCH_RD, S_REM_RD: begin
        rd_en = 1'b1;
      end
      S_REM_WR: begin
        wr_en = 1'b1;
        wr_addr = IdxW'(pos - 1'b1);
      end
      S_CHK_RD, S_OUT_RD: begin
        rd_en = 1'b1;
        rd_addr = cursor[IdxW-1:0];
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !pend;
  assign load_out = (state == S_IDLE) && pend && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hold_time <= HoldReset;
      order_mode <= 1'b0;
      count <= '0;
      cur_ok <= 1'b0;
      cursor <= '0;
      sav_ok <= 1'b0;
      saved <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
      pos <= '0;
      res_expired <= 1'b0;
      res_status <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HOLD) begin
          if (cfg_data != '0) begin
            hold_time <= cfg_data;
          end
        end else begin
          order_mode <= cfg_data[0];
        end
      end
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (load_out) begin
            out_valid <= 1'b1;
            found <= cur_ok;
            handle_out <= cur_ok ? rd_data.handle : '0;
            address_out <= cur_ok ? rd_data.address : '0;
            expired <= res_expired;
            status <= res_status;
            pend <= 1'b0;
          end else if (in_valid && in_ready) begin
            r_addr <= address;
            r_now <= now;
            new_ent.address <= address;
            new_ent.key <= order_key;
            new_ent.handle <= entry_handle;
            new_ent.expiry <= exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];
            res_expired <= 1'b0;
            res_status <= 1'b0;
            state <= S_OUT_RD;
            unique case (action)
              ACT_INSERT: begin
                if (count >= DepthC) begin
                  res_status <= 1'b1;
                end else if (count == '0) begin
                  pos <= '0;
                  state <= S_INS_WR;
                end else begin
                  pos <= count;
                  state <= S_INS_RD;
                end
              end
              ACT_FIND: begin
                pos <= '0;
                state <= S_SRCH_RD;
              end
              ACT_FIND_NEXT: begin
                if (cur_ok) begin
                  pos <= cursor + 1'b1;
                  state <= S_SRCH_RD;
                end
              end
              ACT_PEEK_FIRST: begin
                cur_ok <= (count != '0);
                cursor <= '0;
              end
              ACT_PEEK_NEXT: begin
                if (cur_ok && (cursor + 1'b1 < count)) begin
                  cursor <= cursor + 1'b1;
                end else if (cur_ok) begin
                  cur_ok <= 1'b0;
                  cursor <= '0;
                end else begin
                  cur_ok <= (count != '0);
                  cursor <= '0;
                end
              end
              ACT_REMOVE: begin
                if (cur_ok || count != '0) begin
                  pos <= (cur_ok ? cursor : '0) + 1'b1;
                  state <= S_REM_RD;
                  if (!cur_ok || cursor == '0) begin
                    cur_ok <= 1'b0;
                    cursor <= '0;
                  end else begin
                    cursor <= cursor - 1'b1;
                  end
                  if (sav_ok) begin
                    if (saved == (cur_ok ? cursor : '0)) begin
                      sav_ok <= 1'b0;
                      saved <= '0;
                    end else if (saved > (cur_ok ? cursor : '0)) begin
                      saved <= saved - 1'b1;
                    end
                  end
                end
              end
              ACT_CHECK: begin
                if (cur_ok) begin
                  state <= S_CHK_RD;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                cur_ok <= 1'b0;
                cursor <= '0;
                sav_ok <= 1'b0;
                saved <= '0;
              end
              ACT_SAVE: begin
                sav_ok <= cur_ok;
                saved <= cursor;
              end
              ACT_RESTORE: begin
                cur_ok <= sav_ok;
                cursor <= saved;
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (goes_first) begin
            pos <= pos - 1'b1;
            state <= (pos == CntW'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          count <= count + 1'b1;
          if (cur_ok && cursor >= pos) cursor <= cursor + 1'b1;
          if (sav_ok && saved >= pos) saved <= saved + 1'b1;
          state <= S_OUT_RD;
        end
        S_SRCH_RD: begin
          if (pos >= count) begin
            cur_ok <= 1'b0;
            cursor <= '0;
            state <= S_OUT_RD;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (cmp_res.eq) begin
            cur_ok <= 1'b1;
            cursor <= pos;
            state <= S_OUT_RD;
          end else begin
            pos <= pos + 1'b1;
            state <= S_SRCH_RD;
          end
        end
        S_REM_RD: begin
          if (pos >= count) begin
            count <= count - 1'b1;
            state <= S_OUT_RD;
          end else begin
            state <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          pos <= pos + 1'b1;
          state <= S_REM_RD;
        end
        S_CHK_RD: state <= S_CHK_CMP;
        S_CHK_CMP: begin
          res_expired <= cmp_res.lt;
          state <= S_OUT_RD;
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: state <= S_DONE;
        S_DONE: begin
          pend <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count never exceeds depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DepthC)
    else $error("entry count over depth");
  // valid cursor always inside table when idle
  a_cursor_in: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cur_ok) |-> cursor < count)
    else $error("cursor past table end");
  // no request accepted while a result is pending
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    pend |-> !in_ready)
    else $error("accept while result pending");
  // a drop leaves the count unchanged
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_INSERT && count == DepthC) |=> count == DepthC)
    else $error("dropped insert changed count");

endmodule

// ----- tb/expiry_sorted_neighbor_table_tb.sv -----
`timescale 1ns / 100ps
// Testbench for expiry_sorted_neighbor_table: directed and random requests,
// with results checked against an in-bench model of the sorted table.
// Depends on esnt_pkg and the RTL top level.
module expiry_sorted_neighbor_table_tb;
  import esnt_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ActW-1:0] action = '0;
  logic [AddrW-1:0] address = '0;
  logic [KeyW-1:0] order_key = '0;
  logic [HandleW-1:0] entry_handle = '0;
  logic [TimeW-1:0] now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [HandleW-1:0] handle_out;
  logic [AddrW-1:0] address_out;
  logic expired;
  logic status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [TimeW-1:0] cfg_data = '0;

  expiry_sorted_neighbor_table #(.TABLE_DEPTH(Depth)) u_top (
    .clk, .rst, .in_valid, .in_ready, .action, .address, .order_key,
    .entry_handle, .now, .out_valid, .out_ready, .found, .handle_out,
    .address_out, .expired, .status, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result of one request as the block should report it
  typedef struct packed {
    logic found;
    logic [HandleW-1:0] handle;
    logic [AddrW-1:0] address;
    logic expired;
    logic status;
  } lookup_result_t;

  lookup_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit rx_stall_mode = 1'b1;   // when clear the receiver never stalls

  // model of the table
  entry_t tbl[Depth];
  int count;
  bit cur_ok, sav_ok;
  int cur, sav;
  logic [TimeW-1:0] hold;
  logic mode;

  function automatic void model_reset();
    count = 0;
    cur_ok = 0; cur = 0;
    sav_ok = 0; sav = 0;
    hold = HoldReset;
    mode = 1'b0;
  endfunction

  function automatic void model_config(logic idx, logic [TimeW-1:0] val);
    if (idx == CFG_HOLD) begin
      if (val != 0) hold = val;
    end else begin
      mode = val[0];
    end
  endfunction

  // cursor lookup from a start slot; a miss leaves no cursor
  function automatic void model_search(int start, logic [AddrW-1:0] a);
    for (int i = start; i < count; i++) begin
      if (tbl[i].address == a) begin
        cur_ok = 1; cur = i;
        return;
      end
    end
    cur_ok = 0; cur = 0;
  endfunction

  function automatic lookup_result_t model_step(logic [ActW-1:0] act,
      logic [AddrW-1:0] a, logic [KeyW-1:0] k, logic [HandleW-1:0] h,
      logic [TimeW-1:0] t);
    lookup_result_t res;
    logic [TimeW:0] sum;
    int pos, r;
    bit precedes;
    res = '0;
    case (act)
      ACT_INSERT: begin
        if (count >= Depth) begin
          res.status = 1'b1;
        end else begin
          sum = {1'b0, t} + {1'b0, hold};
          pos = count;
          while (pos > 0) begin
            precedes = mode ? (a > tbl[pos-1].address) : (k < tbl[pos-1].key);
            if (!precedes) break;
            pos--;
          end
          for (int i = count; i > pos; i--) tbl[i] = tbl[i-1];
          tbl[pos].address = a;
          tbl[pos].key = k;
          tbl[pos].expiry = sum[TimeW] ? '1 : sum[TimeW-1:0];
          tbl[pos].handle = h;
          count++;
          if (cur_ok && cur >= pos) cur++;
          if (sav_ok && sav >= pos) sav++;
        end
      end
      ACT_FIND: model_search(0, a);
      ACT_FIND_NEXT: if (cur_ok) model_search(cur + 1, a);
      ACT_PEEK_FIRST: begin
        cur_ok = count > 0; cur = 0;
      end
      ACT_PEEK_NEXT: begin
        if (cur_ok && cur + 1 < count) cur++;
        else if (cur_ok) begin
          cur_ok = 0; cur = 0;
        end else begin
          cur_ok = count > 0; cur = 0;
        end
      end
      ACT_REMOVE: begin
        if (cur_ok || count > 0) begin
          r = cur_ok ? cur : 0;
          for (int i = r; i + 1 < count; i++) tbl[i] = tbl[i+1];
          count--;
          cur_ok = r != 0;
          cur = (r == 0) ? 0 : r - 1;
          if (sav_ok) begin
            if (sav == r) begin
              sav_ok = 0; sav = 0;
            end else if (sav > r) begin
              sav--;
            end
          end
        end
      end
      ACT_CHECK: res.expired = cur_ok && (tbl[cur].expiry < t);
      ACT_CLEAR: begin
        count = 0;
        cur_ok = 0; cur = 0;
        sav_ok = 0; sav = 0;
      end
      ACT_SAVE: begin
        sav_ok = cur_ok; sav = cur;
      end
      ACT_RESTORE: begin
        cur_ok = sav_ok; cur = sav;
      end
      default: ;
    endcase
    if (cur_ok && cur < count) begin
      res.found = 1'b1;
      res.handle = tbl[cur].handle;
      res.address = tbl[cur].address;
    end
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // drive one request and wait for its acceptance; the model runs at acceptance
  task automatic send_request(logic [ActW-1:0] act, logic [AddrW-1:0] a,
      logic [KeyW-1:0] k, logic [HandleW-1:0] h, logic [TimeW-1:0] t);
    int n;
    action <= act;
    address <= a;
    order_key <= k;
    entry_handle <= h;
    now <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(model_step(act, a, k, h, t));
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * Depth + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TimeW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(idx, val);
    @(posedge clk);
  endtask

  // receiver: random stalls, checks each result against the oldest expectation
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result with no request pending: found=%0b addr=%h", $time,
                 found, address_out);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (found !== exp_r.found || handle_out !== exp_r.handle ||
            address_out !== exp_r.address || expired !== exp_r.expired ||
            status !== exp_r.status) begin
          $display("%0t mismatch expected f=%0b h=%h a=%h x=%0b s=%0b",
                   $time, exp_r.found, exp_r.handle, exp_r.address,
                   exp_r.expired, exp_r.status);
          $display("%0t          actual   f=%0b h=%h a=%h x=%0b s=%0b",
                   $time, found, handle_out, address_out, expired, status);
          errors++;
        end
      end
    end
    out_ready <= rx_stall_mode ? ($urandom_range(99) < 70) : 1'b1;
  end

  // run-time watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // addresses drawn from a small pool so finds often hit
  function automatic logic [AddrW-1:0] pick_addr();
    int p;
    p = $urandom_range(9);
    if (p < 7) return AddrW'($urandom_range(12));
    if (p == 7) return '1;
    return $urandom;
  endfunction

  function automatic logic [ActW-1:0] pick_action();
    int p;
    p = $urandom_range(99);
    if (p < 30) return ACT_INSERT;
    if (p < 40) return ACT_FIND;
    if (p < 47) return ACT_FIND_NEXT;
    if (p < 53) return ACT_PEEK_FIRST;
    if (p < 63) return ACT_PEEK_NEXT;
    if (p < 76) return ACT_REMOVE;
    if (p < 86) return ACT_CHECK;
    if (p < 88) return ACT_CLEAR;
    if (p < 93) return ACT_SAVE;
    if (p < 98) return ACT_RESTORE;
    return ActW'($urandom_range(15, 10));   // undefined codes
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send_request(pick_action(), pick_addr(), $urandom, HandleW'($urandom), $urandom);
  endtask

  // directed: ordering, full table, overflowing expiry, cursor corner cases
  task automatic test_directed();
    send_request(ACT_REMOVE, 0, 0, 0, 0);          // remove on empty table
    send_request(ACT_PEEK_NEXT, 0, 0, 0, 0);       // from none on empty
    send_request(ACT_CHECK, 0, 0, 0, 0);           // no cursor
    send_request(ACT_FIND_NEXT, 3, 0, 0, 0);       // no cursor, no search
    for (int i = 0; i < Depth; i++)
      send_request(ACT_INSERT, i, (i * 7) % 5, HandleW'(8'hA0 + i), 32'hFFFF_F000);
    send_request(ACT_INSERT, '1, '1, 8'hFF, '1);   // full, dropped
    send_request(ACT_FIND, 4, 0, 0, 0);
    send_request(ACT_SAVE, 0, 0, 0, 0);
    send_request(ACT_CHECK, 0, 0, 0, '1);          // saturated expiry, not below
    send_request(ACT_REMOVE, 0, 0, 0, 0);          // saved entry goes away
    send_request(ACT_RESTORE, 0, 0, 0, 0);
    send_request(ACT_PEEK_FIRST, 0, 0, 0, 0);
    send_request(ACT_REMOVE, 0, 0, 0, 0);          // head: cursor none
    send_request(ACT_FIND, 32'hDEAD_BEEF, 0, 0, 0); // miss
    send_request(4'hF, 0, 0, 0, 0);
    send_request(ACT_CLEAR, 0, 0, 0, 0);
    send_request(ACT_INSERT, 0, 0, 8'h00, 0);
    send_request(ACT_PEEK_FIRST, 0, 0, 0, 0);
    send_request(ACT_CHECK, 0, 0, 0, 32'd6001);    // expiry 6000 below now
    send_request(ACT_PEEK_NEXT, 0, 0, 0, 0);       // past the end
  endtask

  task automatic test_ascending_default();
    random_burst(100);
  endtask

  // descending by address, including a mode flip over existing entries
  task automatic test_descending();
    drain();
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_HOLD, 32'd1);
    random_burst(110);
  endtask

  // zero hold time is ignored; maximum hold saturates expiry
  task automatic test_hold_extremes();
    drain();
    write_reg(CFG_HOLD, '1);
    write_reg(CFG_HOLD, '0);
    write_reg(CFG_MODE, 32'd0);
    random_burst(60);
    // hold off until the block has answered everything
    drain();
    write_reg(CFG_HOLD, 32'd250);
    random_burst(60);
  endtask

  task automatic test_no_stall();
    drain();
    rx_stall_mode = 1'b0;
    write_reg(CFG_MODE, 32'd1);
    random_burst(60);
    rx_stall_mode = 1'b1;
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ascending_default();
    test_descending();
    test_hold_extremes();
    test_no_stall();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
